@@ src/assert_macros.svh @@
// Assertion macros shared by the snapshot record parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MERP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MERP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MERP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define MERP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/merp_pkg.sv @@
// Types, field codes and field tables of the snapshot entity record parser.
package merp_pkg;

    localparam int RESULT_DEPTH = 4;
    localparam int NUM_FIELDS = 12;
    localparam int SCORE_BIT = 10;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COUNT,
        PH_RECORD
    } phase_t;

    typedef enum logic [3:0] {
        FC_ID     = 4'd0,
        FC_MASK   = 4'd1,
        FC_TYPE   = 4'd2,
        FC_POSX   = 4'd3,
        FC_POSY   = 4'd4,
        FC_VELX   = 4'd5,
        FC_VELY   = 4'd6,
        FC_HEALTH = 4'd7,
        FC_STATUS = 4'd8,
        FC_ORIENT = 4'd9,
        FC_DEAD   = 4'd10,
        FC_SCORE  = 4'd11
    } field_code_t;

    typedef struct packed {
        logic [15:0] entity_index;
        logic [3:0]  field_code;
        logic [31:0] field_value;
        logic        entity_done;
        logic        parse_status;
    } result_t;

    // Byte length of each field.
    function automatic logic [2:0] field_len(input logic [3:0] code);
        logic [2:0] len;
        case (code)
            FC_ID, FC_ORIENT, FC_SCORE: len = 3'd4;
            FC_TYPE, FC_STATUS, FC_DEAD: len = 3'd1;
            default: len = 3'd2;
        endcase
        return len;
    endfunction

    // Presence-mask bit that selects an optional field.
    function automatic logic [3:0] field_bit(input logic [3:0] code);
        logic [3:0] pos;
        case (code)
            FC_POSX:   pos = 4'd1;
            FC_POSY:   pos = 4'd2;
            FC_VELX:   pos = 4'd3;
            FC_VELY:   pos = 4'd4;
            FC_HEALTH: pos = 4'd5;
            FC_STATUS: pos = 4'd6;
            FC_ORIENT: pos = 4'd7;
            FC_DEAD:   pos = 4'd8;
            FC_SCORE:  pos = 4'(SCORE_BIT);
            default:   pos = 4'd0;
        endcase
        return pos;
    endfunction

    // Next optional field present after code, or the id code if none is left.
    function automatic logic [3:0] next_field(input logic [3:0] code,
                                              input logic [15:0] mask);
        logic [3:0] found;
        logic       hit;
        found = FC_ID;
        hit = 1'b0;
        for (int k = 2; k < NUM_FIELDS; k++) begin
            if (!hit && 4'(k) > code && mask[field_bit(4'(k))]) begin
                found = 4'(k);
                hit = 1'b1;
            end
        end
        return found;
    endfunction

endpackage

@@ src/merp_if.sv @@
// Valid/ready channel interfaces for payload bytes and parse results.
interface merp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       payload_start;
    logic       payload_end;

    modport source (output valid, output data_byte, output payload_start,
                    output payload_end, input ready);
    modport sink (input valid, input data_byte, input payload_start,
                  input payload_end, output ready);
endinterface

interface merp_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] entity_index;
    logic [3:0]  field_code;
    logic [31:0] field_value;
    logic        entity_done;
    logic        parse_status;

    modport source (output valid, output entity_index, output field_code,
                    output field_value, output entity_done, output parse_status,
                    input ready);
    modport sink (input valid, input entity_index, input field_code,
                  input field_value, input entity_done, input parse_status,
                  output ready);
endinterface

@@ src/merp_result_fifo.sv @@
// Small result queue that takes up to two results per cycle and gives one.
`include "assert_macros.svh"

module merp_result_fifo #(
    parameter int Depth = merp_pkg::RESULT_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_n,
    input  merp_pkg::result_t wdata0,
    input  merp_pkg::result_t wdata1,
    input  logic              pop,
    output merp_pkg::result_t rdata,
    output logic              not_empty,
    output logic              has_room
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    merp_pkg::result_t mem [Depth];

    logic [PtrW-1:0] wptr_reg, wptr_next;
    logic [PtrW-1:0] rptr_reg, rptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [PtrW-1:0] wptr_inc;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wptr_inc = ptr_inc(wptr_reg);
    assign rdata = mem[rptr_reg];
    assign not_empty = (count_reg != '0);
    // Room for the worst case of two results from one byte.
    assign has_room = (count_reg <= CntW'(Depth - 2));

    always_comb
    begin
        case (push_n)
            2'd1: wptr_next = wptr_inc;
            2'd2: wptr_next = ptr_inc(wptr_inc);
            default: wptr_next = wptr_reg;
        endcase
        rptr_next = pop ? ptr_inc(rptr_reg) : rptr_reg;
        count_next = count_reg + CntW'(push_n) - CntW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wptr_reg] <= wdata0;
        end
        if (push_n == 2'd2)
        begin
            mem[wptr_inc] <= wdata1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    `MERP_ASSERT_IMPL(a_push_fits, clk, rst_n, push_n != 2'd0, has_room, "result queue overflow")
    `MERP_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, not_empty, "pop from empty result queue")
    `MERP_ASSERT_NEXT(a_count_track, clk, rst_n, 1'b1, count_reg == $past(count_reg) + CntW'($past(push_n)) - CntW'($past(pop)), "result count mismatch")

endmodule

@@ src/masked_entity_record_parser.sv @@
// Top level of the snapshot entity record parser.
//
// The payload channel carries one snapshot payload byte per transfer, with
// payload_start on the first byte and payload_end on the last. The byte
// stream is a big-endian 16-bit entity count followed by that many records
// (32-bit id, 16-bit presence mask, then the optional fields the mask selects).
// The result channel gives one transfer per completed field, tagged with the
// entity index and field code, plus one error result when the payload ends
// inside the count, inside a record or before all entities have arrived.
// A byte is parsed in the cycle it is taken; its results are written to the
// result queue, which drives the result channel. One byte is taken per cycle
// while the four-entry result queue has room for two results, so the sustained
// rate is one byte per cycle; a byte that causes two results queues both, and
// the result channel gives them one per transfer. When the receiver stalls,
// results wait in the queue and the payload channel drops ready once fewer than
// two entries are free. Reset returns the parser to idle with an empty queue;
// bytes are ignored until the next payload_start.
`include "assert_macros.svh"

module masked_entity_record_parser #(
    parameter int ResultDepth = merp_pkg::RESULT_DEPTH
) (
    input logic          clk,
    input logic          rst_n,
    merp_byte_if.sink    payload,
    merp_result_if.source result
);

    merp_pkg::phase_t phase_reg, phase_next, phase_step, phase_eff;

    logic [15:0] ent_reg, ent_next;
    logic [15:0] rec_reg, rec_next;
    logic [15:0] mask_reg, mask_next;
    logic [3:0]  cur_reg, cur_next;
    logic [2:0]  bytes_reg, bytes_next;
    logic [31:0] asm_reg, asm_next;

    // Values after the byte is consumed, before the end-of-payload check.
    logic [15:0] ent_step, rec_step, mask_step, ent_base, rec_base, mask_base;
    logic [3:0]  cur_step, cur_base;
    logic [2:0]  bytes_step, bytes_base, cnt;
    logic [31:0] asm_step, asm_base, asm_shift;

    logic [3:0]  code, nx;
    logic [2:0]  len;
    logic [31:0] value;
    logic [15:0] mask_upd;
    logic        count_done, field_done, last_field;

    logic              accept;
    logic              res0_valid, res1_valid;
    logic [1:0]        push_n;
    merp_pkg::result_t res0, res1, wdata0, wdata1, rdata;
    logic              not_empty, has_room;

    assign accept = payload.valid && payload.ready;
    assign payload.ready = has_room;

    // Per-byte field assembly.
    always_comb
    begin
        if (payload.payload_start)
        begin
            phase_eff  = merp_pkg::PH_COUNT;
            ent_base   = '0;
            rec_base   = '0;
            mask_base  = '0;
            cur_base   = merp_pkg::FC_ID;
            bytes_base = '0;
            asm_base   = '0;
        end
        else
        begin
            phase_eff  = phase_reg;
            ent_base   = ent_reg;
            rec_base   = rec_reg;
            mask_base  = mask_reg;
            cur_base   = cur_reg;
            bytes_base = bytes_reg;
            asm_base   = asm_reg;
        end

        asm_shift = {asm_base[23:0], payload.data_byte};
        cnt = bytes_base + 3'd1;
        code = (cur_base < 4'(merp_pkg::NUM_FIELDS)) ? cur_base : merp_pkg::FC_ID;
        len = merp_pkg::field_len(code);

        count_done = (phase_eff == merp_pkg::PH_COUNT) && (cnt >= 3'd2);
        field_done = (phase_eff == merp_pkg::PH_RECORD) && (cnt >= len);

        case (len)
            3'd1: value = {24'd0, asm_shift[7:0]};
            3'd2:
            begin
                if (code >= merp_pkg::FC_POSX && code <= merp_pkg::FC_HEALTH)
                begin
                    value = {{16{asm_shift[15]}}, asm_shift[15:0]};
                end
                else
                begin
                    value = {16'd0, asm_shift[15:0]};
                end
            end
            default: value = asm_shift;
        endcase

        mask_upd = (code == merp_pkg::FC_MASK) ? asm_shift[15:0] : mask_base;
        nx = (code == merp_pkg::FC_ID) ? merp_pkg::FC_MASK
                                       : merp_pkg::next_field(code, mask_upd);
        last_field = (nx == merp_pkg::FC_ID);

        ent_step   = ent_base;
        rec_step   = rec_base;
        mask_step  = mask_base;
        cur_step   = cur_base;
        bytes_step = bytes_base;
        asm_step   = asm_base;

        if (phase_eff == merp_pkg::PH_COUNT)
        begin
            asm_step   = asm_shift;
            bytes_step = cnt;
            if (count_done)
            begin
                ent_step   = asm_shift[15:0];
                asm_step   = '0;
                bytes_step = '0;
                cur_step   = merp_pkg::FC_ID;
                rec_step   = '0;
            end
        end
        else if (phase_eff == merp_pkg::PH_RECORD)
        begin
            asm_step   = asm_shift;
            bytes_step = cnt;
            if (field_done)
            begin
                asm_step   = '0;
                bytes_step = '0;
                mask_step  = mask_upd;
                if (!last_field)
                begin
                    cur_step = nx;
                end
                else
                begin
                    cur_step  = merp_pkg::FC_ID;
                    mask_step = '0;
                    ent_step  = ent_base - 16'd1;
                    rec_step  = rec_base + 16'd1;
                end
            end
        end
    end

    // Parse phase, next state.
    always_comb
    begin
        phase_step = phase_eff;
        case (phase_eff)
            merp_pkg::PH_COUNT:
            begin
                if (count_done)
                begin
                    phase_step = (asm_shift[15:0] == 16'd0) ? merp_pkg::PH_IDLE
                                                            : merp_pkg::PH_RECORD;
                end
            end
            merp_pkg::PH_RECORD:
            begin
                if (field_done && last_field && ent_base == 16'd1)
                begin
                    phase_step = merp_pkg::PH_IDLE;
                end
            end
            default: phase_step = merp_pkg::PH_IDLE;
        endcase

        if (!accept)
        begin
            phase_next = phase_reg;
        end
        else if (payload.payload_end)
        begin
            phase_next = merp_pkg::PH_IDLE;
        end
        else
        begin
            phase_next = phase_step;
        end
    end

    // Results and register updates.
    always_comb
    begin
        res0.entity_index = rec_base;
        res0.field_code   = code;
        res0.field_value  = value;
        res0.entity_done  = last_field;
        res0.parse_status = 1'b0;
        res0_valid = accept && field_done;

        // A truncated count reports entity 0 and the id code.
        res1.entity_index = (phase_step == merp_pkg::PH_RECORD) ? rec_step : 16'd0;
        res1.field_code   = (phase_step == merp_pkg::PH_RECORD) ? cur_step
                                                                : merp_pkg::FC_ID;
        res1.field_value  = '0;
        res1.entity_done  = 1'b0;
        res1.parse_status = 1'b1;
        res1_valid = accept && payload.payload_end && (phase_step != merp_pkg::PH_IDLE);

        push_n = 2'(res0_valid) + 2'(res1_valid);
        wdata0 = res0_valid ? res0 : res1;
        wdata1 = res1;

        if (accept)
        begin
            ent_next  = ent_step;
            rec_next  = rec_step;
            mask_next = mask_step;
            cur_next  = cur_step;
            if (payload.payload_end)
            begin
                bytes_next = '0;
                asm_next   = '0;
            end
            else
            begin
                bytes_next = bytes_step;
                asm_next   = asm_step;
            end
        end
        else
        begin
            ent_next   = ent_reg;
            rec_next   = rec_reg;
            mask_next  = mask_reg;
            cur_next   = cur_reg;
            bytes_next = bytes_reg;
            asm_next   = asm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= merp_pkg::PH_IDLE;
            ent_reg   <= '0;
            rec_reg   <= '0;
            mask_reg  <= '0;
            cur_reg   <= merp_pkg::FC_ID;
            bytes_reg <= '0;
            asm_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            ent_reg   <= ent_next;
            rec_reg   <= rec_next;
            mask_reg  <= mask_next;
            cur_reg   <= cur_next;
            bytes_reg <= bytes_next;
            asm_reg   <= asm_next;
        end
    end

    merp_result_fifo #(
        .Depth (ResultDepth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .wdata0    (wdata0),
        .wdata1    (wdata1),
        .pop       (result.valid && result.ready),
        .rdata     (rdata),
        .not_empty (not_empty),
        .has_room  (has_room)
    );

    assign result.valid        = not_empty;
    assign result.entity_index = rdata.entity_index;
    assign result.field_code   = rdata.field_code;
    assign result.field_value  = rdata.field_value;
    assign result.entity_done  = rdata.entity_done;
    assign result.parse_status = rdata.parse_status;

    `MERP_ASSERT_IMPL(a_idle_clear, clk, rst_n, phase_reg == merp_pkg::PH_IDLE, bytes_reg == 3'd0 && asm_reg == 32'd0, "idle parser holds partial field")
    `MERP_ASSERT_IMPL(a_record_left, clk, rst_n, phase_reg == merp_pkg::PH_RECORD, ent_reg != 16'd0, "record phase with no entities left")
    `MERP_ASSERT_IMPL(a_count_bytes, clk, rst_n, phase_reg == merp_pkg::PH_COUNT, bytes_reg < 3'd2, "count phase overran two bytes")

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the snapshot entity record parser.
module tb_top;
    import merp_pkg::*;

    localparam int ITEM_TARGET = 1500;
    localparam int QUIET_AFTER = 1300;
    localparam int LONG_HOLD = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [7:0] data;
        bit         sop;
        bit         eop;
    } pl_byte_t;

    // Tracks the parse of the byte stream and holds the field results still owed.
    class snapshot_checker;
        result_t     expected_fields[$];
        int          errors;
        int          used_bytes;
        int          fields_seen;
        int          faults_seen;
        phase_t      phase;
        logic [15:0] entities_to_go;
        logic [15:0] rec_index;
        logic [15:0] sel_mask;
        field_code_t cur_field;
        int          got_bytes;
        logic [31:0] shift_reg;

        function new();
            phase = PH_IDLE;
            entities_to_go = '0;
            rec_index = '0;
            sel_mask = '0;
            cur_field = FC_ID;
            got_bytes = 0;
            shift_reg = '0;
        endfunction

        static function int bytes_of(field_code_t c);
            int n;
            case (c)
                FC_ID, FC_ORIENT, FC_SCORE: n = 4;
                FC_TYPE, FC_STATUS, FC_DEAD: n = 1;
                default: n = 2;
            endcase
            return n;
        endfunction

        static function int mask_bit_of(field_code_t c);
            int pos;
            case (c)
                FC_POSX: pos = 1;
                FC_POSY: pos = 2;
                FC_VELX: pos = 3;
                FC_VELY: pos = 4;
                FC_HEALTH: pos = 5;
                FC_STATUS: pos = 6;
                FC_ORIENT: pos = 7;
                FC_DEAD: pos = 8;
                FC_SCORE: pos = SCORE_BIT;
                default: pos = 0;
            endcase
            return pos;
        endfunction

        // The id code doubles as "no optional field left".
        function field_code_t following_field(field_code_t c);
            for (int k = int'(c) + 1; k < NUM_FIELDS; k++)
            begin
                if (k >= int'(FC_TYPE) && sel_mask[mask_bit_of(field_code_t'(k))])
                    return field_code_t'(k);
            end
            return FC_ID;
        endfunction

        function void owe(logic [15:0] idx, field_code_t c, logic [31:0] v, logic done,
                          logic fault);
            result_t r;
            r.entity_index = idx;
            r.field_code = c;
            r.field_value = v;
            r.entity_done = done;
            r.parse_status = fault;
            expected_fields.insert(expected_fields.size(), r);
        endfunction

        function void take_byte(logic [7:0] b, logic start, logic last);
            int          n;
            logic [31:0] value;
            field_code_t nxt;
            if (start)
            begin
                phase = PH_COUNT;
                entities_to_go = '0;
                rec_index = '0;
                sel_mask = '0;
                cur_field = FC_ID;
                got_bytes = 0;
                shift_reg = '0;
            end
            if (phase != PH_IDLE)
                used_bytes++;
            if (phase == PH_COUNT)
            begin
                shift_reg = {shift_reg[23:0], b};
                got_bytes++;
                if (got_bytes >= 2)
                begin
                    entities_to_go = shift_reg[15:0];
                    shift_reg = '0;
                    got_bytes = 0;
                    cur_field = FC_ID;
                    rec_index = '0;
                    phase = (entities_to_go == 16'd0) ? PH_IDLE : PH_RECORD;
                end
            end
            else if (phase == PH_RECORD)
            begin
                shift_reg = {shift_reg[23:0], b};
                got_bytes++;
                n = bytes_of(cur_field);
                if (got_bytes >= n)
                begin
                    value = shift_reg;
                    if (n == 1)
                        value = {24'h0, value[7:0]};
                    else if (n == 2)
                    begin
                        value = {16'h0, value[15:0]};
                        // Position, velocity and health are signed 16-bit quantities.
                        if (cur_field >= FC_POSX && cur_field <= FC_HEALTH && value[15])
                            value[31:16] = 16'hFFFF;
                    end
                    if (cur_field == FC_MASK)
                        sel_mask = value[15:0];
                    nxt = (cur_field == FC_ID) ? FC_MASK : following_field(cur_field);
                    owe(rec_index, cur_field, value, nxt == FC_ID, 1'b0);
                    shift_reg = '0;
                    got_bytes = 0;
                    if (nxt != FC_ID)
                        cur_field = nxt;
                    else
                    begin
                        cur_field = FC_ID;
                        sel_mask = '0;
                        entities_to_go = entities_to_go - 16'd1;
                        rec_index = rec_index + 16'd1;
                        if (entities_to_go == 16'd0)
                            phase = PH_IDLE;
                    end
                end
            end
            if (last)
            begin
                if (phase == PH_COUNT)
                    owe(16'd0, FC_ID, 32'd0, 1'b0, 1'b1);
                else if (phase == PH_RECORD)
                    owe(rec_index, cur_field, 32'd0, 1'b0, 1'b1);
                phase = PH_IDLE;
                got_bytes = 0;
                shift_reg = '0;
            end
        endfunction

        function void check_field(result_t got);
            result_t want;
            if (expected_fields.size() == 0)
            begin
                $error("unexpected result: entity %0d field %0d value %h status %0d",
                       got.entity_index, got.field_code, got.field_value, got.parse_status);
                errors++;
                return;
            end
            want = expected_fields.pop_front();
            if (got.parse_status === 1'b1)
                faults_seen++;
            else
                fields_seen++;
            if (got.entity_index !== want.entity_index)
            begin
                $error("entity_index: expected %0d, got %0d", want.entity_index,
                       got.entity_index);
                errors++;
            end
            if (got.field_code !== want.field_code)
            begin
                $error("field_code: expected %0d, got %0d", want.field_code, got.field_code);
                errors++;
            end
            if (got.field_value !== want.field_value)
            begin
                $error("field_value: expected %h, got %h", want.field_value, got.field_value);
                errors++;
            end
            if (got.entity_done !== want.entity_done)
            begin
                $error("entity_done: expected %0d, got %0d", want.entity_done,
                       got.entity_done);
                errors++;
            end
            if (got.parse_status !== want.parse_status)
            begin
                $error("parse_status: expected %0d, got %0d", want.parse_status,
                       got.parse_status);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_fields.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    merp_byte_if   payload_ch();
    merp_result_if result_ch();

    masked_entity_record_parser u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .payload(payload_ch),
        .result (result_ch)
    );

    snapshot_checker sb = new();
    pl_byte_t        packet_bytes[$];
    bit              quiet = 1'b0;
    bit              tx_gappy = 1'b0;
    bit              hold_request = 1'b0;
    int              cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Both channels are observed in one process so that a byte is always noted
    // before any result of the same edge is checked.
    always @(posedge clk)
    begin
        result_t seen;
        if (rst_n)
        begin
            if (payload_ch.valid && payload_ch.ready)
                sb.take_byte(payload_ch.data_byte, payload_ch.payload_start,
                             payload_ch.payload_end);
            if (result_ch.valid && result_ch.ready)
            begin
                seen.entity_index = result_ch.entity_index;
                seen.field_code = result_ch.field_code;
                seen.field_value = result_ch.field_value;
                seen.entity_done = result_ch.entity_done;
                seen.parse_status = result_ch.parse_status;
                sb.check_field(seen);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stall bursts, calm stretches, and one long hold-off.
    initial
    begin
        bit stall_mode;
        stall_mode = 1'b1;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                stall_mode = ~stall_mode;
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && stall_mode && $urandom_range(0, 2) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit s, input bit e);
        if (!quiet && tx_gappy && $urandom_range(0, 3) == 0)
        begin
            payload_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        payload_ch.valid <= 1'b1;
        payload_ch.data_byte <= b;
        payload_ch.payload_start <= s;
        payload_ch.payload_end <= e;
        do @(posedge clk); while (!payload_ch.ready);
    endtask

    task automatic drain();
        payload_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    function automatic void append(input logic [31:0] value, input int n);
        pl_byte_t pb;
        for (int i = n - 1; i >= 0; i--)
        begin
            pb.data = value[8 * i +: 8];
            pb.sop = 1'b0;
            pb.eop = 1'b0;
            packet_bytes.insert(packet_bytes.size(), pb);
        end
    endfunction

    // Field contents lean toward the sign boundaries and the all-zero/all-one corners.
    function automatic logic [31:0] rand_value(input int n);
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'h0;
            1: v = 32'hFFFF_FFFF;
            2: v = 32'h1 << (8 * n - 1);
            3: v = (32'h1 << (8 * n - 1)) - 32'h1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_mask();
        logic [15:0] m;
        case ($urandom_range(0, 9))
            0: m = 16'h0000;
            1: m = 16'hFFFF;
            default: m = 16'($urandom);
        endcase
        return m;
    endfunction

    function automatic void add_record(input logic [15:0] m);
        field_code_t c;
        append(rand_value(4), 4);
        append({16'h0, m}, 2);
        for (int k = int'(FC_TYPE); k < NUM_FIELDS; k++)
        begin
            c = field_code_t'(k);
            if (m[snapshot_checker::mask_bit_of(c)])
                append(rand_value(snapshot_checker::bytes_of(c)), snapshot_checker::bytes_of(c));
        end
    endfunction

    // Mostly well-formed snapshots; the rest are truncated, cut short by a restart,
    // padded with ignored bytes, or stray bytes outside any payload.
    task automatic send_random_packet();
        int kind;
        int count;
        int records;
        int cut;
        kind = $urandom_range(0, 99);
        packet_bytes.delete();
        if (kind >= 95)
        begin
            repeat ($urandom_range(1, 4)) append($urandom, 1);
            packet_bytes[$].eop = ($urandom_range(0, 1) == 1);
        end
        else
        begin
            if (kind < 6)
            begin
                count = (kind == 0) ? 65535 : $urandom_range(5, 65535);
                records = $urandom_range(0, 2);
            end
            else
            begin
                count = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 3);
                records = count;
            end
            append(count, 2);
            packet_bytes[0].sop = 1'b1;
            repeat (records) add_record(rand_mask());
            if (kind >= 70 && kind < 80)
                repeat ($urandom_range(1, 3)) append($urandom, 1);
            if (kind >= 80 && kind < 90)
            begin
                cut = $urandom_range(1, packet_bytes.size() - 1);
                while (packet_bytes.size() > cut)
                    void'(packet_bytes.pop_back());
            end
            // A packet left without an end mark is cut off by the next start.
            packet_bytes[$].eop = (kind < 90);
        end
        foreach (packet_bytes[i])
            send_byte(packet_bytes[i].data, packet_bytes[i].sop, packet_bytes[i].eop);
    endtask

    initial
    begin
        int packets;
        packets = 0;
        rst_n = 1'b0;
        payload_ch.valid <= 1'b0;
        payload_ch.data_byte <= 8'h00;
        payload_ch.payload_start <= 1'b0;
        payload_ch.payload_end <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A stray byte while idle, then a count cut off on its first byte.
        send_byte(8'h5A, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);
        // Zero entities; the byte after the count is ignored.
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b1);
        // Restart inside the count, then one record whose mask also sets an unused bit.
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h02, 1'b0, 1'b0);
        send_byte(8'h08, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        // Two entities announced, the end comes right after the first one's score.
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h02, 1'b0, 1'b0);
        repeat (4) send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFD, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        drain();

        while (sb.used_bytes < ITEM_TARGET)
        begin
            packets++;
            if (packets == 20)
                hold_request = 1'b1;
            if (packets == 40)
                drain();
            if (sb.used_bytes >= QUIET_AFTER)
                quiet = 1'b1;
            tx_gappy = ($urandom_range(0, 2) != 0);
            send_random_packet();
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d parsed payload bytes in %0d random packets.",
                 sb.used_bytes, packets);
        $display("Checked %0d field results and %0d parse error results.",
                 sb.fields_seen, sb.faults_seen);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
